FILE: rtl/closed_tour_length_unit_macros.svh
// Assertion helpers for the closed tour length unit.
// Synthesis builds see empty bodies.
`ifndef CLOSED_TOUR_LENGTH_UNIT_MACROS_SVH
`define CLOSED_TOUR_LENGTH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("closed_tour_length_unit: same-cycle check failed");

// Next-cycle implication.
`define CTL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("closed_tour_length_unit: next-cycle check failed");

`else

`define CTL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ctl_pkg.sv
package ctl_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 16;
    localparam int SUM_BITS   = 2 * COORD_BITS + 1;
    localparam int TOTAL_BITS = 40;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    // One city per input transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic                         last_city;
    } city_t;

    // One closed tour length per output transaction
    typedef struct packed {
        logic [TOTAL_BITS-1:0] tour_length;
        logic                  length_saturated;
    } result_t;

    // Control that travels with a segment down the root chain
    typedef struct packed {
        logic valid;
        logic closing;   // closing segment of a tour, triggers the result
    } seg_tag_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_CLOSE,
        ST_DRAIN
    } ctl_state_t;

endpackage

FILE: rtl/closed_tour_length_unit.sv
// Closed tour length unit.
// Cities come in on the city channel (city_valid / city_stall), one per
// transaction, in tour order, with last_city set on the final one. For each
// pair of consecutive cities, and for the closing hop back to the first
// city, the unit computes floor(sqrt(dx^2 + dy^2)) with FRAC_BITS fraction
// bits and adds it to a 40-bit total that clamps at its maximum and then
// reports length_saturated. One result transaction leaves per tour.
// Segments run through a row of ROOT_BITS root cells, one root bit per cell,
// behind a three-stage difference/square/sum front end; a new segment can
// enter every cycle. A city that is not the last is taken without a stall.
// A last city blocks the channel until its result is loaded into the output
// register. ROOT_BITS = (33 + 2*FRAC_BITS + 1) / 2.
// The result register holds its transaction while result_stall is high;
// a finished tour waits for that register to free up, and the city channel
// stays stalled until the tour's result has been loaded.
// Reset clears the tour state, the total and all valid bits; the unit is
// ready for a first city on the first cycle after reset.
`include "closed_tour_length_unit_macros.svh"

module closed_tour_length_unit
    import ctl_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    city_valid,
    output logic    city_stall,
    input  city_t   city,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int RAD_BITS  = SUM_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_BITS;
    localparam int REM_W     = ROOT_BITS + 2;

    ctl_state_t                   state_reg, state_next;
    logic                         in_tour_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [TOTAL_BITS-1:0]        total_reg;
    logic                         sat_reg;
    logic                         done_reg;
    logic                         result_valid_reg;
    result_t                      result_reg;

    logic                         city_fire;
    logic                         out_free;
    logic                         load_out;
    seg_tag_t                     push_tag;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    seg_tag_t                     rad_tag;
    logic [RAD_W-1:0]             rad;

    seg_tag_t                     chain_tag  [0:ROOT_BITS];
    logic [RAD_W-1:0]             chain_rad  [0:ROOT_BITS];
    logic [REM_W-1:0]             chain_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0]         chain_root [0:ROOT_BITS];

    seg_tag_t                     exit_tag;
    logic [TOTAL_BITS-1:0]        seg_ext;
    logic [TOTAL_BITS:0]          sum_ext;

    assign city_fire = city_valid && !city_stall;
    assign out_free  = !result_valid_reg || !result_stall;
    assign load_out  = (state_reg == ST_DRAIN) && done_reg && out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (city_fire && city.last_city)
                begin
                    state_next = in_tour_reg ? ST_CLOSE : ST_DRAIN;
                end
            end
            ST_CLOSE:
            begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (load_out)
                begin
                    state_next = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // Outputs of the sequencer: channel stall and segment launch
    always_comb
    begin
        city_stall       = 1'b1;
        push_tag.valid   = 1'b0;
        push_tag.closing = 1'b0;
        ax               = prev_x_reg;
        ay               = prev_y_reg;
        bx               = prev_x_reg;
        by               = prev_y_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                city_stall       = 1'b0;
                push_tag.valid   = city_valid && (in_tour_reg || city.last_city);
                push_tag.closing = city_valid && city.last_city && !in_tour_reg;
                ax               = in_tour_reg ? prev_x_reg : city.x_coord;
                ay               = in_tour_reg ? prev_y_reg : city.y_coord;
                bx               = city.x_coord;
                by               = city.y_coord;
            end
            ST_CLOSE:
            begin
                push_tag.valid   = 1'b1;
                push_tag.closing = 1'b1;
                ax               = first_x_reg;
                ay               = first_y_reg;
            end
            ST_DRAIN:
            begin
                city_stall       = 1'b1;
            end
            default:
            begin
                city_stall       = 1'b1;
            end
        endcase
    end

    // Tour endpoints
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCEPT;
            in_tour_reg <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (city_fire)
            begin
                if (!in_tour_reg)
                begin
                    first_x_reg <= city.x_coord;
                    first_y_reg <= city.y_coord;
                end
                prev_x_reg  <= city.x_coord;
                prev_y_reg  <= city.y_coord;
                in_tour_reg <= !city.last_city;
            end
        end
    end

    // Difference, square and sum front end
    ctl_seg_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_tag (push_tag),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by       (by),
        .rad_tag  (rad_tag),
        .rad      (rad)
    );

    // Root chain, one result bit per cell
    assign chain_tag[0]  = rad_tag;
    assign chain_rad[0]  = rad;
    assign chain_rem[0]  = '0;
    assign chain_root[0] = '0;

    for (genvar gi = 0; gi < ROOT_BITS; gi++)
    begin : g_cell
        ctl_root_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag_in   (chain_tag[gi]),
            .rad_in   (chain_rad[gi]),
            .rem_in   (chain_rem[gi]),
            .root_in  (chain_root[gi]),
            .tag_out  (chain_tag[gi+1]),
            .rad_out  (chain_rad[gi+1]),
            .rem_out  (chain_rem[gi+1]),
            .root_out (chain_root[gi+1])
        );
    end

    // Saturating accumulate at the chain exit
    always_comb
    begin
        exit_tag = chain_tag[ROOT_BITS];
        seg_ext  = {{(TOTAL_BITS-ROOT_BITS){1'b0}}, chain_root[ROOT_BITS]};
        sum_ext  = {1'b0, total_reg} + {1'b0, seg_ext};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (load_out)
        begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (exit_tag.valid)
        begin
            total_reg <= sum_ext[TOTAL_BITS] ? TOTAL_MAX : sum_ext[TOTAL_BITS-1:0];
            sat_reg   <= sat_reg || sum_ext[TOTAL_BITS];
            done_reg  <= exit_tag.closing;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg.tour_length      <= total_reg;
            result_reg.length_saturated <= sat_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `CTL_ASSERT_IMP(a_close_exit_in_drain, clk, rst_n,
        exit_tag.valid && exit_tag.closing, (state_reg == ST_DRAIN) && !done_reg)
    `CTL_ASSERT_IMP(a_done_only_in_drain, clk, rst_n, done_reg, state_reg == ST_DRAIN)
    `CTL_ASSERT_IMP(a_sat_pins_total, clk, rst_n, sat_reg, total_reg == TOTAL_MAX)
    `CTL_ASSERT_IMP(a_close_after_last, clk, rst_n,
        state_reg == ST_CLOSE, $past(city_fire && city.last_city))
    `CTL_ASSERT_NXT(a_load_clears, clk, rst_n, load_out,
        result_valid_reg && !done_reg && (total_reg == '0))

endmodule

FILE: rtl/ctl_seg_prep.sv
module ctl_seg_prep
    import ctl_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  seg_tag_t                     push_tag,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    output seg_tag_t                     rad_tag,
    output logic [2*((SUM_BITS+2*FRAC_BITS+1)/2)-1:0] rad
);

    localparam int RAD_BITS  = SUM_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_BITS;

    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS-1:0]        dx_next, dy_next;
    logic [COORD_BITS-1:0]        dx_reg, dy_reg;
    logic [2*COORD_BITS-1:0]      sqx_next, sqy_next;
    logic [2*COORD_BITS-1:0]      sqx_reg, sqy_reg;
    logic [SUM_BITS-1:0]          sum_next;
    logic [RAD_W-1:0]             rad_next;
    logic [RAD_W-1:0]             rad_reg;
    seg_tag_t                     tag1_reg, tag2_reg, tag3_reg;

    // Stage 1: absolute differences
    always_comb
    begin
        diff_x  = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
        diff_y  = $signed({ay[COORD_BITS-1], ay}) - $signed({by[COORD_BITS-1], by});
        dx_next = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
        dy_next = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    end

    // Stage 2: squares
    always_comb
    begin
        sqx_next = (2*COORD_BITS)'(dx_reg) * (2*COORD_BITS)'(dx_reg);
        sqy_next = (2*COORD_BITS)'(dy_reg) * (2*COORD_BITS)'(dy_reg);
    end

    // Stage 3: sum, scaled up for the fraction bits of the root
    always_comb
    begin
        sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        rad_next = {{(RAD_W-SUM_BITS){1'b0}}, sum_next} << (2 * FRAC_BITS);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= push_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        rad_reg <= rad_next;
    end

    assign rad_tag = tag3_reg;
    assign rad     = rad_reg;

endmodule

FILE: rtl/ctl_root_cell.sv
module ctl_root_cell
    import ctl_pkg::*;
#(
    parameter int ROOT_BITS = 25
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  seg_tag_t               tag_in,
    input  logic [2*ROOT_BITS-1:0] rad_in,
    input  logic [ROOT_BITS+1:0]   rem_in,
    input  logic [ROOT_BITS-1:0]   root_in,
    output seg_tag_t               tag_out,
    output logic [2*ROOT_BITS-1:0] rad_out,
    output logic [ROOT_BITS+1:0]   rem_out,
    output logic [ROOT_BITS-1:0]   root_out
);

    localparam int RAD_W = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS + 2;

    logic [REM_W-1:0]     rem_sh, trial;
    logic                 ge;
    seg_tag_t             tag_reg;
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;

    // One root bit: bring down the next radicand pair, trial subtract
    always_comb
    begin
        rem_sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[ROOT_BITS-2:0], ge};
        rad_next  = {rad_in[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign tag_out  = tag_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule
